FILE: src/medt_pkg.sv
`timescale 1ns / 1ps

package medt_pkg;

	localparam int TIME_WIDTH       = 32;
	localparam int COUNT_OUT_WIDTH  = 11;
	localparam int MAX_BITS_DEFAULT = 1024;
	localparam int PROD_WIDTH       = TIME_WIDTH + 10;

	localparam logic [6:0] PERCENT_SCALE = 7'd100;

	localparam logic [6:0] ACCEPT_PCT_RESET = 7'd25;
	localparam logic [9:0] END_PCT_RESET    = 10'd300;
	localparam logic [3:0] HEADER_RESET     = 4'd2;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_SHORT = 2'd2,
		KIND_DROP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_ACCEPT_PCT = 2'd0,
		REG_END_PCT    = 2'd1,
		REG_HEADER     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] edge_time;
		logic                  new_level;
	} in_item_t;

	typedef struct packed {
		kind_t                      kind;
		logic                       data_bit;
		logic [COUNT_OUT_WIDTH-1:0] bit_count;
	} out_item_t;

	typedef struct packed {
		logic awaiting_first_low;
		logic awaiting_high_period;
		logic uncalibrated;
	} flags_t;

	typedef struct packed {
		logic [6:0] accept_pct;
		logic [9:0] end_pct;
		logic [3:0] header_bits;
	} cfg_t;

endpackage

FILE: src/medt_step.sv
`timescale 1ns / 1ps

module medt_step import medt_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEFAULT,
	parameter int CNT_W    = $clog2(MAX_BITS + 1)
) (
	input  in_item_t              item,
	input  cfg_t                  cfg,
	input  logic [TIME_WIDTH-1:0] last_time,
	input  logic [TIME_WIDTH-1:0] low_period,
	input  logic [TIME_WIDTH-1:0] high_period,
	input  flags_t                flags,
	input  logic [CNT_W-1:0]      bits_rcvd,
	output logic [TIME_WIDTH-1:0] last_time_nx,
	output logic [TIME_WIDTH-1:0] low_period_nx,
	output logic [TIME_WIDTH-1:0] high_period_nx,
	output flags_t                flags_nx,
	output logic [CNT_W-1:0]      bits_rcvd_nx,
	output logic                  res_valid,
	output out_item_t             res
);

	logic [TIME_WIDTH-1:0] t;
	logic                  lvl;
	logic [TIME_WIDTH-1:0] lt;
	logic [TIME_WIDTH-1:0] lp;
	logic [TIME_WIDTH-1:0] hp;
	flags_t                fl;
	logic [TIME_WIDTH-1:0] period;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [TIME_WIDTH-1:0] dev;
	logic [PROD_WIDTH-1:0] dev_x100;
	logic [PROD_WIDTH-1:0] end_lim;
	logic [PROD_WIDTH-1:0] acc_lim;
	logic [CNT_W-1:0]      hdr;
	logic [CNT_W-1:0]      br_inc;
	logic [CNT_W-1:0]      pay;
	logic [CNT_W-1:0]      pay_inc;

	assign t   = item.edge_time;
	assign lvl = item.new_level;
	assign hdr = CNT_W'(cfg.header_bits);

	// calibration updates, applied before the timing test of the same edge
	always_comb begin
		lt = last_time;
		lp = low_period;
		hp = high_period;
		fl = flags;
		if (low_period == '0 && !flags.awaiting_first_low && !lvl) begin
			lp = t - last_time;
			fl.uncalibrated = 1'b0;
		end
		if (flags.awaiting_high_period && lvl && !flags.awaiting_first_low) begin
			hp = t - last_time;
			fl.awaiting_high_period = 1'b0;
			fl.uncalibrated = 1'b0;
		end
		if (flags.awaiting_first_low && !lvl) begin
			lt = t;
			fl.awaiting_first_low = 1'b0;
		end
	end

	assign period   = lvl ? hp : lp;
	assign elapsed  = t - lt;
	assign dev      = (period > elapsed) ? (period - elapsed) : (elapsed - period);
	assign dev_x100 = PROD_WIDTH'(dev) * PROD_WIDTH'(PERCENT_SCALE);
	assign end_lim  = PROD_WIDTH'(period) * PROD_WIDTH'(cfg.end_pct);
	assign acc_lim  = PROD_WIDTH'(period) * PROD_WIDTH'(cfg.accept_pct);

	assign br_inc  = bits_rcvd + CNT_W'(1);
	assign pay     = (bits_rcvd > hdr) ? (bits_rcvd - hdr) : '0;
	assign pay_inc = (br_inc > hdr) ? (br_inc - hdr) : '0;

	always_comb begin
		last_time_nx   = lt;
		low_period_nx  = lp;
		high_period_nx = hp;
		flags_nx       = fl;
		bits_rcvd_nx   = bits_rcvd;
		res_valid      = 1'b0;
		res.kind       = KIND_DATA;
		res.data_bit   = 1'b0;
		res.bit_count  = '0;
		if (!(fl.uncalibrated || period == '0)) begin
			if (dev_x100 > end_lim) begin
				res_valid = 1'b1;
				if (bits_rcvd < hdr) begin
					res.kind = KIND_SHORT;
				end else begin
					res.kind      = KIND_END;
					res.bit_count = COUNT_OUT_WIDTH'(pay);
				end
				last_time_nx   = '0;
				low_period_nx  = '0;
				high_period_nx = '0;
				flags_nx       = '{1'b1, 1'b1, 1'b1};
				bits_rcvd_nx   = '0;
			end else if (!(dev_x100 > acc_lim)) begin
				last_time_nx = t;
				if (bits_rcvd >= CNT_W'(MAX_BITS)) begin
					res_valid     = 1'b1;
					res.kind      = KIND_DROP;
					res.bit_count = COUNT_OUT_WIDTH'(pay);
				end else begin
					bits_rcvd_nx = br_inc;
					if (br_inc > hdr) begin
						res_valid     = 1'b1;
						res.kind      = KIND_DATA;
						res.data_bit  = ~lvl;
						res.bit_count = COUNT_OUT_WIDTH'(pay_inc);
					end
				end
			end
		end
	end

endmodule

FILE: src/manchester_edge_timing_decoder_core.sv
`timescale 1ns / 1ps
// Path: an accepted edge is registered in the input register, and its result in the output
// register; the step waits while a held result stalls it.
// Throughput: one edge per cycle unless a held result stalls; timing check and state update
// are combinational. A held result freezes the input register; the input stalls once it is full.
// Reset (arst_n low): timing state, counters and valids clear at once; registers
// return to accept 25 %, end 300 %, header 2.
module manchester_edge_timing_decoder_core import medt_pkg::*; #(
	parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_reg_t  cfg_index,
	input  logic [9:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_BITS + 1);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	in_item_t              item_s1;
	logic [TIME_WIDTH-1:0] last_time_q;
	logic [TIME_WIDTH-1:0] low_period_q;
	logic [TIME_WIDTH-1:0] high_period_q;
	flags_t                flags_q;
	logic [CNT_W-1:0]      bits_rcvd_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [TIME_WIDTH-1:0] last_time_nx;
	logic [TIME_WIDTH-1:0] low_period_nx;
	logic [TIME_WIDTH-1:0] high_period_nx;
	flags_t                flags_nx;
	logic [CNT_W-1:0]      bits_rcvd_nx;
	logic                  res_valid;
	out_item_t             res;
	logic                  advance;
	logic                  do_step;

	assign advance   = !out_valid_q || !out_stall;
	assign do_step   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ACCEPT_PCT_RESET, END_PCT_RESET, HEADER_RESET};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ACCEPT_PCT: cfg_q.accept_pct  <= cfg_data[6:0];
				REG_END_PCT:    cfg_q.end_pct     <= cfg_data;
				REG_HEADER:     cfg_q.header_bits <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	medt_step #(
		.MAX_BITS(MAX_BITS),
		.CNT_W(CNT_W)
	) u_step (
		.item(item_s1),
		.cfg(cfg_q),
		.last_time(last_time_q),
		.low_period(low_period_q),
		.high_period(high_period_q),
		.flags(flags_q),
		.bits_rcvd(bits_rcvd_q),
		.last_time_nx(last_time_nx),
		.low_period_nx(low_period_nx),
		.high_period_nx(high_period_nx),
		.flags_nx(flags_nx),
		.bits_rcvd_nx(bits_rcvd_nx),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q   <= '0;
			low_period_q  <= '0;
			high_period_q <= '0;
			flags_q       <= '{1'b1, 1'b1, 1'b1};
			bits_rcvd_q   <= '0;
		end else if (do_step) begin
			last_time_q   <= last_time_nx;
			low_period_q  <= low_period_nx;
			high_period_q <= high_period_nx;
			flags_q       <= flags_nx;
			bits_rcvd_q   <= bits_rcvd_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= do_step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && res_valid) begin
			out_q <= res;
		end
	end

endmodule

FILE: src/medt_checker.sv
`timescale 1ns / 1ps

module medt_checker import medt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// a held result transaction keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input side only backs up behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_DATA |-> out_data.bit_count != '0)
		else $error("data bit with zero payload count");

	a_short_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_DATA |-> !out_data.data_bit)
		else $error("data bit set on non-data result");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_SHORT |-> out_data.bit_count == '0)
		else $error("short message with nonzero count");

endmodule

bind manchester_edge_timing_decoder_core medt_checker u_medt_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import medt_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam cfg_reg_t REG_NONE = cfg_reg_t'(2'd3);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_ACCEPT_PCT;
	logic [9:0] cfg_data = '0;

	manchester_edge_timing_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// decoder model: registers and timing state
	logic [6:0] accept_lim = ACCEPT_PCT_RESET;
	logic [9:0] end_lim = END_PCT_RESET;
	logic [3:0] header_len = HEADER_RESET;
	logic [31:0] last_edge_us = '0;
	logic [31:0] low_per = '0;
	logic [31:0] high_per = '0;
	logic want_first_low = 1'b1;
	logic want_high_per = 1'b1;
	logic not_locked = 1'b1;
	int unsigned bits_seen = 0;

	in_item_t edge_q[$];
	out_item_t decoded_q[$];
	logic [31:0] clock_us;
	int unsigned queued_edges = 0;
	int unsigned accepted_edges = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit hold_sender = 1'b0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_left = 0;
	int quiet = 0;
	int errors = 0;
	int kind_seen [0:3] = '{0, 0, 0, 0};

	function automatic void clear_decoder();
		last_edge_us = '0;
		low_per = '0;
		high_per = '0;
		want_first_low = 1'b1;
		want_high_per = 1'b1;
		not_locked = 1'b1;
		bits_seen = 0;
	endfunction

	function automatic logic [10:0] payload_bits();
		return (bits_seen > header_len) ? 11'(bits_seen - header_len) : '0;
	endfunction

	function automatic bit beyond_pct(logic [31:0] dev, logic [31:0] per, logic [9:0] pct);
		logic [63:0] lhs;
		logic [63:0] rhs;
		lhs = 64'(dev) * 64'd100;
		rhs = 64'(per) * 64'(pct);
		return lhs > rhs;
	endfunction

	function automatic void decode_edge(in_item_t e);
		logic [31:0] t;
		logic [31:0] per;
		logic [31:0] gap;
		logic [31:0] dev;
		out_item_t r;
		t = e.edge_time;
		if (low_per == 0 && !want_first_low && !e.new_level) begin
			low_per = t - last_edge_us;
			not_locked = 1'b0;
		end
		if (want_high_per && e.new_level && !want_first_low) begin
			high_per = t - last_edge_us;
			want_high_per = 1'b0;
			not_locked = 1'b0;
		end
		if (want_first_low && !e.new_level) begin
			last_edge_us = t;
			want_first_low = 1'b0;
		end
		per = e.new_level ? high_per : low_per;
		if (not_locked || per == 0)
			return;
		gap = t - last_edge_us;
		dev = (per > gap) ? per - gap : gap - per;
		r = '0;
		if (beyond_pct(dev, per, end_lim)) begin
			if (bits_seen < header_len) begin
				r.kind = KIND_SHORT;
			end else begin
				r.kind = KIND_END;
				r.bit_count = payload_bits();
			end
			decoded_q.push_back(r);
			clear_decoder();
			return;
		end
		if (beyond_pct(dev, per, 10'(accept_lim)))
			return;
		last_edge_us = t;
		if (bits_seen >= MAX_BITS_DEFAULT) begin
			r.kind = KIND_DROP;
			r.bit_count = payload_bits();
			decoded_q.push_back(r);
			return;
		end
		bits_seen++;
		if (bits_seen <= header_len)
			return;
		r.kind = KIND_DATA;
		r.data_bit = !e.new_level;
		r.bit_count = payload_bits();
		decoded_q.push_back(r);
	endfunction

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (decoded_q.size() == 0) begin
			errors++;
			if (errors <= 100)
				$display("%0t: unexpected result: expected none, actual kind %0d bit %0b count %0d",
					$time, got.kind, got.data_bit, got.bit_count);
			return;
		end
		want = decoded_q.pop_front();
		if (got.kind !== want.kind || got.data_bit !== want.data_bit ||
				got.bit_count !== want.bit_count) begin
			errors++;
			if (errors <= 100)
				$display("%0t: mismatch: expected kind %0d bit %0b count %0d, actual kind %0d bit %0b count %0d",
					$time, want.kind, want.data_bit, want.bit_count,
					got.kind, got.data_bit, got.bit_count);
		end else begin
			kind_seen[got.kind]++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_edge(in_data);
				accepted_edges++;
			end
			if (!in_valid || !in_stall) begin
				if (edge_q.size() != 0 && !hold_sender && $urandom_range(99) >= send_idle_pct) begin
					in_data <= edge_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_reqs != holds_done) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic put_edge(int unsigned dt, bit lvl);
		clock_us += dt;
		edge_q.push_back({clock_us, lvl});
		queued_edges++;
	endtask

	// edge off the bit grid: does not move the grid
	task automatic put_glitch(int unsigned off, bit lvl);
		edge_q.push_back({clock_us + off, lvl});
		queued_edges++;
	endtask

	task automatic send_message(int unsigned nbits, int unsigned per, int unsigned jit,
			int unsigned same_pct, int unsigned glitch_pct);
		int unsigned j;
		bit lvl;
		bit nxt;
		j = per / 100 * jit;
		put_edge(2 * per + $urandom_range(per), 1'b0);
		lvl = 1'b0;
		for (int unsigned i = 0; i < nbits; i++) begin
			// alternate at the start so both periods lock on a full bit
			nxt = (i < 3 || $urandom_range(99) >= same_pct) ? !lvl : lvl;
			if ($urandom_range(99) < glitch_pct)
				put_glitch($urandom_range(per - 1, 1), $urandom_range(1));
			if (nxt == lvl)
				put_glitch(per / 2, !lvl);
			put_edge(per - j + $urandom_range(2 * j), nxt);
			lvl = nxt;
		end
		put_edge(12 * per + $urandom_range(per), $urandom_range(1));
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (accepted_edges != queued_edges || decoded_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_ACCEPT_PCT: accept_lim = val[6:0];
			REG_END_PCT:    end_lim = val;
			REG_HEADER:     header_len = val[3:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(int unsigned acc, int unsigned endp, int unsigned hdr,
			int unsigned jit, int unsigned idle_in, int unsigned idle_out,
			int unsigned budget, bit with_capacity, bit with_pressure);
		int unsigned start;
		int unsigned nb;
		int unsigned per;
		write_reg(REG_ACCEPT_PCT, 10'(acc) | (10'($urandom) & 10'h380));
		write_reg(REG_END_PCT, 10'(endp));
		write_reg(REG_HEADER, 10'(hdr) | (10'($urandom) & 10'h3F0));
		cfg_valid <= 1'b0;
		send_idle_pct = idle_in;
		stall_pct = idle_out;
		start = queued_edges;
		if (with_capacity)
			send_message(MAX_BITS_DEFAULT + 16, 100, 5, 10, 0);
		while (queued_edges - start < budget) begin
			nb = ($urandom_range(99) < 15) ? $urandom_range(header_len) : $urandom_range(40, 1);
			per = ($urandom_range(99) < 8) ? $urandom_range(1 << 27, 1 << 20)
				: $urandom_range(3000, 20);
			send_message(nb, per, jit, 25, 5);
		end
		if (with_pressure) begin
			hold_reqs++;
			while (accepted_edges < start + 60)
				@(posedge clk);
			hold_sender = 1'b1;
			while (decoded_q.size() != 0)
				@(posedge clk);
			hold_sender = 1'b0;
		end
		wait_idle();
	endtask

	initial begin
		clear_decoder();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// lock, window edges, end threshold, timestamp wrap
		clock_us = 32'hFFFF_FFC0;
		put_edge(5, 1'b1);
		put_edge(10, 1'b0);
		put_edge(100, 1'b1);
		put_edge(100, 1'b0);
		put_edge(50, 1'b1);
		put_edge(50, 1'b1);
		put_edge(125, 1'b0);
		put_edge(126, 1'b1);
		put_edge(274, 1'b1);
		put_edge(1, 1'b1);
		// zero low period, measured again
		put_edge(1000, 1'b0);
		put_edge(0, 1'b0);
		put_edge(100, 1'b1);
		put_edge(100, 1'b0);
		put_edge(100, 1'b1);
		put_edge(5000, 1'b0);
		// too short
		put_edge(1000, 1'b0);
		put_edge(100, 1'b1);
		put_edge(5000, 1'b1);
		// largest periods
		put_edge(1000, 1'b0);
		put_edge(32'hFFFF_FFFF, 1'b1);
		put_edge(32'hFFFF_FFFF, 1'b0);
		put_edge(32'hFFFF_FFFF, 1'b1);
		wait_idle();
		write_reg(REG_END_PCT, 10'd0);
		write_reg(REG_NONE, 10'h3FF);
		cfg_valid <= 1'b0;
		put_edge(1, 1'b0);
		wait_idle();

		clock_us = $urandom();
		run_phase(25, 300, 2, 5, 0, 0, 1250, 1'b1, 1'b0);
		run_phase(0, 1000, 0, 0, 60, 0, 90, 1'b0, 1'b0);
		run_phase(100, 100, 15, 10, 0, 60, 90, 1'b0, 1'b0);
		run_phase(127, 1023, 7, 20, 23, 23, 90, 1'b0, 1'b0);
		run_phase(40, 60, 1, 8, 0, 0, 90, 1'b0, 1'b1);

		$display("Ran %0d edges over 7 register settings, idle/stall mixes, a long output hold-off and a sender pause.",
			accepted_edges);
		$display("Checked %0d data bits, %0d message ends, %0d short messages, %0d capacity drops; %0d errors.",
			kind_seen[KIND_DATA], kind_seen[KIND_END], kind_seen[KIND_SHORT], kind_seen[KIND_DROP],
			errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
